// ----- hdl/lams_pkg.sv -----
`timescale 1ns / 1ps
// Package for the labeled adjacency matrix store.
// Holds action and status codes, controller states and the command/status structs.
// No dependencies.
package lams_pkg;

  // Action codes of an input word.
  localparam logic [1:0] ACT_ADD_NODE = 2'd0;
  localparam logic [1:0] ACT_ADD_EDGE = 2'd1;
  localparam logic [1:0] ACT_LOOKUP   = 2'd2;

  // Fixed field widths of the stream words.
  localparam int unsigned LabelW  = 8;
  localparam int unsigned FieldIW = 4;
  localparam int unsigned WeightW = 32;
  localparam int unsigned CountW  = 5;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_WRITE2,
    S_READ,
    S_DONE
  } state_e;

  // What the executing word needs next from the weight memory.
  typedef enum logic [1:0] {
    KIND_DIRECT,
    KIND_EDGE,
    KIND_READ
  } kind_e;

  typedef struct packed {
    logic in_ready;
    logic clear;
    logic exec;
    logic wr2;
    logic cap_rd;
    logic load_out;
  } lams_cmd_t;

  typedef struct packed {
    logic  clr_last;
    kind_e kind;
    logic  out_free;
  } lams_stat_t;

endpackage

// ----- hdl/lams_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies.
module lams_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/lams_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the labeled adjacency matrix store.
// Depends on lams_pkg.
module lams_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  lams_pkg::lams_stat_t stat_i,
  output lams_pkg::lams_cmd_t  cmd_o
);

  import lams_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:  if (stat_i.clr_last) state_d = S_IDLE;
      S_IDLE:   if (in_valid_i) state_d = S_EXEC;
      S_EXEC: begin
        unique case (stat_i.kind)
          KIND_EDGE: state_d = S_WRITE2;
          KIND_READ: state_d = S_READ;
          default:   state_d = S_DONE;
        endcase
      end
      S_WRITE2: state_d = S_DONE;
      S_READ:   state_d = S_DONE;
      S_DONE:   if (stat_i.out_free) state_d = S_IDLE;
      default:  state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.in_ready = (state_q == S_IDLE);
    cmd_o.clear    = (state_q == S_CLEAR);
    cmd_o.exec     = (state_q == S_EXEC);
    cmd_o.wr2      = (state_q == S_WRITE2);
    cmd_o.cap_rd   = (state_q == S_READ);
    cmd_o.load_out = (state_q == S_DONE) && stat_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/lams_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the labeled adjacency matrix store: word register, labels,
// node count, clear sweep, weight memory port and output register.
// Depends on lams_pkg and lams_ram.
module lams_dp #(
  parameter int unsigned MAX_NODE_COUNT = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lams_pkg::lams_cmd_t                 cmd_i,
  output lams_pkg::lams_stat_t                stat_o,
  input  logic                                in_valid_i,
  input  logic [1:0]                          in_user_i,
  input  logic [lams_pkg::InDataW-1:0]        in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lams_pkg::OutDataW-1:0]       out_data_o
);

  import lams_pkg::*;

  localparam int unsigned IW    = (MAX_NODE_COUNT > 1) ? $clog2(MAX_NODE_COUNT) : 1;
  localparam int unsigned CW    = $clog2(MAX_NODE_COUNT + 1);
  localparam int unsigned Depth = MAX_NODE_COUNT * MAX_NODE_COUNT;
  localparam int unsigned AW    = $clog2(Depth);

  // Word register
  logic [1:0]         act_q;
  logic [LabelW-1:0]  lab_a_q, lab_b_q;
  logic [FieldIW-1:0] from_q, to_q;
  logic [WeightW-1:0] w_q;

  // State
  logic [CW-1:0]     count_q;
  logic [LabelW-1:0] label_q [MAX_NODE_COUNT];
  logic [AW-1:0]     clr_q;

  // Result and output
  status_e           res_st_q;
  logic [WeightW-1:0] res_w_q;
  logic              out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  // Memory port
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [WeightW-1:0] mem_wdata, mem_rdata;

  logic take;
  assign take = cmd_i.in_ready && in_valid_i;

  // Label search: highest stored index wins
  logic          hit_a, hit_b;
  logic [IW-1:0] idx_a, idx_b;

  always_comb begin
    hit_a = 1'b0;
    hit_b = 1'b0;
    idx_a = '0;
    idx_b = '0;
    for (int i = 0; i < MAX_NODE_COUNT; i++) begin
      if (CW'(i) < count_q) begin
        if (label_q[i] == lab_a_q) begin
          hit_a = 1'b1;
          idx_a = IW'(i);
        end
        if (label_q[i] == lab_b_q) begin
          hit_b = 1'b1;
          idx_b = IW'(i);
        end
      end
    end
  end

  logic          full, edge_ok, found;
  logic [IW-1:0] ea, eb;
  logic [AW-1:0] addr_ab, addr_ba, addr_rd;

  assign full    = (count_q >= CW'(MAX_NODE_COUNT));
  assign edge_ok = (32'(from_q) < 32'(count_q)) && (32'(to_q) < 32'(count_q));
  assign found   = hit_a && hit_b;
  assign ea      = IW'(from_q);
  assign eb      = IW'(to_q);
  assign addr_ab = AW'(32'(ea) * MAX_NODE_COUNT + 32'(eb));
  assign addr_ba = AW'(32'(eb) * MAX_NODE_COUNT + 32'(ea));
  assign addr_rd = AW'(32'(idx_a) * MAX_NODE_COUNT + 32'(idx_b));

  always_comb begin
    stat_o.clr_last = (clr_q == AW'(Depth - 1));
    stat_o.out_free = !out_valid_q || out_ready_i;
    stat_o.kind     = KIND_DIRECT;
    if (act_q == ACT_ADD_EDGE && edge_ok) begin
      stat_o.kind = KIND_EDGE;
    end else if (act_q == ACT_LOOKUP && found) begin
      stat_o.kind = KIND_READ;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = clr_q;
    mem_wdata = w_q;
    if (cmd_i.clear) begin
      mem_we    = 1'b1;
      mem_wdata = '0;
    end else if (cmd_i.exec) begin
      if (act_q == ACT_ADD_EDGE) begin
        mem_we   = edge_ok;
        mem_addr = addr_ab;
      end else begin
        mem_addr = addr_rd;
      end
    end else if (cmd_i.wr2) begin
      mem_we   = 1'b1;
      mem_addr = addr_ba;
    end
  end

  lams_ram #(
    .WIDTH(WeightW),
    .DEPTH(Depth)
  ) u_weight_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      act_q   <= in_user_i;
      lab_a_q <= in_data_i[7:0];
      lab_b_q <= in_data_i[15:8];
      from_q  <= in_data_i[19:16];
      to_q    <= in_data_i[23:20];
      w_q     <= in_data_i[55:24];
    end
    if (cmd_i.exec) begin
      case (act_q)
        ACT_ADD_NODE: begin
          res_w_q <= '0;
          if (full) begin
            res_st_q <= ST_FULL;
          end else begin
            res_st_q <= ST_OK;
            label_q[count_q[IW-1:0]] <= lab_a_q;
          end
        end
        ACT_ADD_EDGE: begin
          res_w_q <= '0;
          if (edge_ok) begin
            res_st_q <= ST_OK;
          end else begin
            res_st_q <= ST_BAD_INDEX;
          end
        end
        ACT_LOOKUP: begin
          if (found) begin
            res_st_q <= ST_OK;
            res_w_q  <= '0;
          end else begin
            res_st_q <= ST_NOT_FOUND;
            res_w_q  <= '1;
          end
        end
        default: begin
          res_st_q <= ST_OK;
          res_w_q  <= '0;
        end
      endcase
    end
    if (cmd_i.cap_rd) begin
      res_w_q <= mem_rdata;
    end
    if (cmd_i.load_out) begin
      out_data_q <= {1'b0, CountW'(count_q), res_w_q, res_st_q};
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.exec && act_q == ACT_ADD_NODE && !full) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- hdl/labeled_adjacency_matrix_store.sv -----
`timescale 1ns / 1ps
// Labeled adjacency matrix store: undirected weighted graph with node labels.
// Top level; depends on lams_pkg, lams_ctrl, lams_dp and lams_ram.
//
// Usage:
//   The slave stream takes one command word per handshake, its action on
//   s_axis_tuser: add a node label, write an edge weight symmetrically between
//   two node indices, or look up the weight between two nodes named by their
//   labels. Every word gives exactly one result word on the master stream
//   (status, weight, node count).
//   Sequence: a word is taken in the idle state and executed in the exec state,
//   and its result is loaded into the output register in the done state once
//   that register is free; a valid edge write or a found lookup adds a step
//   for the second write or the registered read of the single-port weight
//   memory. A new word is taken only after the result of the previous one has
//   been loaded into the output register.
//   Reset: after rst_ni is released the block sweeps the weight memory to zero,
//   one entry a cycle, over all MAX_NODE_COUNT * MAX_NODE_COUNT entries (256 at
//   the default) with s_axis_tready low; the node count starts at zero.
//   Stall: a result waits in the output register while m_axis_tready is low;
//   the next word is still taken and executed, and its result is held until
//   the output register frees up.
module labeled_adjacency_matrix_store #(
  parameter int unsigned MAX_NODE_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] action
  input  logic [1:0]  s_axis_tuser,
  // [7:0] first_label, [15:8] second_label, [19:16] from_index,
  // [23:20] to_index, [55:24] edge_weight
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [33:2] weight_out, [38:34] node_count_out, [39] zero
  output logic [39:0] m_axis_tdata
);

  import lams_pkg::*;

  lams_cmd_t  cmd;
  lams_stat_t stat;

  // Sequence each word: take, execute, memory step, hand to the output stage.
  lams_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // Hold labels, count, weight memory and the output register.
  lams_dp #(
    .MAX_NODE_COUNT(MAX_NODE_COUNT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_valid_i (s_axis_tvalid),
    .in_user_i  (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

  assign s_axis_tready = cmd.in_ready;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for labeled_adjacency_matrix_store: directed table plus random words,
// each result checked against a graph predictor or a typed row. Depends on lams_pkg and the RTL.
module testbench;
  import lams_pkg::*;

  localparam int unsigned NODE_LIMIT = 16;
  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int DIR_ROWS            = 23;
  localparam int RAND_WORDS          = 1015;
  localparam int QUIET_LIMIT         = 3000;
  localparam int PRINT_LIMIT         = 50;

  // One command word, fields as they travel on the slave stream.
  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  lab_a;
    logic [7:0]  lab_b;
    logic [3:0]  idx_a;
    logic [3:0]  idx_b;
    logic [31:0] weight;
  } graph_cmd_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] weight;
    logic [4:0]  count;
  } graph_res_t;

  // Directed row: repeated rep times with lab_a stepping by one each time.
  typedef struct {
    logic [1:0]  action;
    logic [7:0]  lab_a;
    logic [7:0]  lab_b;
    logic [3:0]  idx_a;
    logic [3:0]  idx_b;
    logic [31:0] weight;
    int          rep;
    bit          typed;
    status_e     exp_status;
    logic [31:0] exp_weight;
    logic [4:0]  exp_count;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = '0;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  // Typed expectation riding along with the word on the slave side.
  bit          tag_typed = 1'b0;
  graph_res_t  tag_exp = '0;

  // Predictor state: node count, labels, symmetric weight store.
  int unsigned node_total;
  logic [7:0]  node_label [NODE_LIMIT];
  logic [31:0] edge_wt [NODE_LIMIT][NODE_LIMIT];

  graph_res_t  pending_results [$];
  int          err_count = 0;
  int          words_sent = 0;
  int          results_seen = 0;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // empty graph: lookup misses, edge rejected, unused action is a no-op
    '{ACT_LOOKUP,   8'h00, 8'h00, 4'd0,  4'd0,  32'h0000_0000, 1,  1'b1,
      ST_NOT_FOUND, 32'hFFFF_FFFF, 5'd0},
    '{ACT_ADD_EDGE, 8'h00, 8'h00, 4'd0,  4'd0,  32'h0000_0005, 1,  1'b1,
      ST_BAD_INDEX, 32'h0, 5'd0},
    '{ACT_UNUSED,   8'h00, 8'h00, 4'd0,  4'd0,  32'h0000_0000, 1,  1'b1,
      ST_OK, 32'h0, 5'd0},
    // label extremes and a duplicate label
    '{ACT_ADD_NODE, 8'h00, 8'h00, 4'd0,  4'd0,  32'h0, 1, 1'b1, ST_OK, 32'h0, 5'd1},
    '{ACT_ADD_NODE, 8'hFF, 8'h00, 4'd0,  4'd0,  32'h0, 1, 1'b1, ST_OK, 32'h0, 5'd2},
    '{ACT_ADD_NODE, 8'h00, 8'h00, 4'd0,  4'd0,  32'h0, 1, 1'b1, ST_OK, 32'h0, 5'd3},
    // one index out of range on either side
    '{ACT_ADD_EDGE, 8'h00, 8'h00, 4'd0,  4'd15, 32'h1, 1, 1'b1, ST_BAD_INDEX, 32'h0, 5'd3},
    '{ACT_ADD_EDGE, 8'h00, 8'h00, 4'd15, 4'd0,  32'h1, 1, 1'b1, ST_BAD_INDEX, 32'h0, 5'd3},
    // weight extremes, diagonal writes, a stored minus one
    '{ACT_ADD_EDGE, 8'h00, 8'h00, 4'd1,  4'd2,  32'h8000_0000, 1, 1'b0, ST_OK, 32'h0, 5'd0},
    '{ACT_ADD_EDGE, 8'h00, 8'h00, 4'd2,  4'd2,  32'h7FFF_FFFF, 1, 1'b0, ST_OK, 32'h0, 5'd0},
    '{ACT_ADD_EDGE, 8'h00, 8'h00, 4'd1,  4'd1,  32'hFFFF_FFFF, 1, 1'b0, ST_OK, 32'h0, 5'd0},
    // duplicate label 0x00 resolves to the higher index
    '{ACT_LOOKUP,   8'hFF, 8'h00, 4'd0,  4'd0,  32'h0, 1, 1'b0, ST_OK, 32'h0, 5'd0},
    '{ACT_LOOKUP,   8'h00, 8'h00, 4'd0,  4'd0,  32'h0, 1, 1'b0, ST_OK, 32'h0, 5'd0},
    '{ACT_LOOKUP,   8'hFF, 8'hFF, 4'd0,  4'd0,  32'h0, 1, 1'b0, ST_OK, 32'h0, 5'd0},
    // miss on either label
    '{ACT_LOOKUP,   8'hFF, 8'h5A, 4'd0,  4'd0,  32'h0, 1, 1'b1,
      ST_NOT_FOUND, 32'hFFFF_FFFF, 5'd3},
    '{ACT_LOOKUP,   8'h5A, 8'h00, 4'd0,  4'd0,  32'h0, 1, 1'b1,
      ST_NOT_FOUND, 32'hFFFF_FFFF, 5'd3},
    // fill the label table, then overflow it
    '{ACT_ADD_NODE, 8'h10, 8'h00, 4'd0,  4'd0,  32'h0, 13, 1'b0, ST_OK, 32'h0, 5'd0},
    '{ACT_ADD_NODE, 8'h77, 8'h00, 4'd0,  4'd0,  32'h0, 1, 1'b1, ST_FULL, 32'h0, 5'd16},
    // top index once the table is full
    '{ACT_ADD_EDGE, 8'h00, 8'h00, 4'd15, 4'd2,  32'h1234_5678, 1, 1'b0, ST_OK, 32'h0, 5'd0},
    '{ACT_ADD_EDGE, 8'h00, 8'h00, 4'd15, 4'd15, 32'hA5A5_A5A5, 1, 1'b0, ST_OK, 32'h0, 5'd0},
    '{ACT_LOOKUP,   8'h1C, 8'h00, 4'd0,  4'd0,  32'h0, 1, 1'b0, ST_OK, 32'h0, 5'd0},
    '{ACT_LOOKUP,   8'h1C, 8'h1C, 4'd0,  4'd0,  32'h0, 1, 1'b0, ST_OK, 32'h0, 5'd0},
    // unused action with every field bit set
    '{ACT_UNUSED,   8'hFF, 8'hFF, 4'd15, 4'd15, 32'hFFFF_FFFF, 1, 1'b1, ST_OK, 32'h0, 5'd16}
  };

  labeled_adjacency_matrix_store u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one word to the predicted graph and return its result.
  function automatic graph_res_t graph_apply(input graph_cmd_t c);
    graph_res_t r;
    int hit_a;
    int hit_b;
    r.status = ST_OK;
    r.weight = '0;
    case (c.action)
      ACT_ADD_NODE: begin
        if (node_total >= NODE_LIMIT) begin
          r.status = ST_FULL;
        end else begin
          node_label[node_total] = c.lab_a;
          node_total++;
        end
      end
      ACT_ADD_EDGE: begin
        if (c.idx_a >= node_total || c.idx_b >= node_total) begin
          r.status = ST_BAD_INDEX;
        end else begin
          edge_wt[c.idx_a][c.idx_b] = c.weight;
          edge_wt[c.idx_b][c.idx_a] = c.weight;
        end
      end
      ACT_LOOKUP: begin
        hit_a = -1;
        hit_b = -1;
        // scan upward so the highest matching index wins
        for (int i = 0; i < node_total; i++) begin
          if (node_label[i] == c.lab_a) hit_a = i;
          if (node_label[i] == c.lab_b) hit_b = i;
        end
        if (hit_a >= 0 && hit_b >= 0) begin
          r.weight = edge_wt[hit_a][hit_b];
        end else begin
          r.status = ST_NOT_FOUND;
          r.weight = '1;
        end
      end
      default: ;
    endcase
    r.count = node_total[4:0];
    return r;
  endfunction

  // Random word: mostly edges and lookups on stored labels, some noise.
  function automatic graph_cmd_t pick_random_cmd();
    graph_cmd_t c;
    int sel;
    sel     = $urandom_range(0, 99);
    c.lab_a = 8'($urandom);
    c.lab_b = 8'($urandom);
    c.idx_a = 4'($urandom);
    c.idx_b = 4'($urandom);
    case ($urandom_range(0, 7))
      0:       c.weight = 32'h8000_0000;
      1:       c.weight = 32'h7FFF_FFFF;
      2:       c.weight = 32'hFFFF_FFFF;
      3:       c.weight = 32'h0;
      default: c.weight = $urandom;
    endcase
    if (sel < 8) c.action = ACT_ADD_NODE;
    else if (sel < 12) c.action = ACT_UNUSED;
    else if (sel < 45) c.action = ACT_ADD_EDGE;
    else c.action = ACT_LOOKUP;
    if (c.action == ACT_LOOKUP && node_total > 0) begin
      if ($urandom_range(0, 99) < 85) c.lab_a = node_label[$urandom_range(0, node_total - 1)];
      if ($urandom_range(0, 99) < 85) c.lab_b = node_label[$urandom_range(0, node_total - 1)];
    end
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_LIMIT) $display("MISMATCH at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  // Offer one word, with random gaps ahead of it, and hold until it is taken.
  // tvalid stays high into the next word when no gap is drawn.
  task automatic send_word(input graph_cmd_t c, input bit typed, input graph_res_t exp);
    while (!calm && $urandom_range(0, 99) < 29) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.action;
    s_axis_tdata  <= {c.weight, c.idx_b, c.idx_a, c.lab_b, c.lab_a};
    tag_typed     <= typed;
    tag_exp       <= exp;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
  endtask

  // Predict on every accepted word; a typed row overrides the predicted result.
  always @(posedge clk_i) begin : accept_mon
    graph_cmd_t c;
    graph_res_t r;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      c.action = s_axis_tuser;
      c.lab_a  = s_axis_tdata[7:0];
      c.lab_b  = s_axis_tdata[15:8];
      c.idx_a  = s_axis_tdata[19:16];
      c.idx_b  = s_axis_tdata[23:20];
      c.weight = s_axis_tdata[55:24];
      r = graph_apply(c);
      pending_results.push_back(tag_typed ? tag_exp : r);
    end
  end

  // Stall the result side at random, except during the calm stretch.
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 29);
  end

  always @(posedge clk_i) begin : result_chk
    graph_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[1:0] !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    m_axis_tdata[1:0], want.status));
        if (m_axis_tdata[33:2] !== want.weight)
          report_mismatch($sformatf("weight got %h want %h",
                                    m_axis_tdata[33:2], want.weight));
        if (m_axis_tdata[38:34] !== want.count)
          report_mismatch($sformatf("node count got %0d want %0d",
                                    m_axis_tdata[38:34], want.count));
      end
    end
  end

  // Watchdog: end the run if neither side moves a word for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stim
    graph_cmd_t c;
    graph_res_t exp;
    node_total = 0;
    for (int i = 0; i < NODE_LIMIT; i++) begin
      node_label[i] = '0;
      for (int j = 0; j < NODE_LIMIT; j++) edge_wt[i][j] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table; the block holds tready low while it clears its memory.
    foreach (dir_rows[n]) begin
      for (int k = 0; k < dir_rows[n].rep; k++) begin
        c.action   = dir_rows[n].action;
        c.lab_a    = dir_rows[n].lab_a + 8'(k);
        c.lab_b    = dir_rows[n].lab_b;
        c.idx_a    = dir_rows[n].idx_a;
        c.idx_b    = dir_rows[n].idx_b;
        c.weight   = dir_rows[n].weight;
        exp.status = dir_rows[n].exp_status;
        exp.weight = dir_rows[n].exp_weight;
        exp.count  = dir_rows[n].exp_count;
        send_word(c, dir_rows[n].typed, exp);
      end
    end

    // Random words, with a stretch of back-to-back traffic in the middle.
    exp = '0;
    for (int n = 0; n < RAND_WORDS; n++) begin
      calm = (n >= 400 && n < 560);
      c = pick_random_cmd();
      send_word(c, 1'b0, exp);
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    // Drain, then keep the clock running so that any stray word would show.
    while (results_seen < words_sent) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (err_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
